// File: hw/rtl/ntps_pkg.sv
// Shared constants and widths for the nearest transformed point search unit.
package ntps_pkg;

    // Default depth of the point store.
    localparam int DEF_MAX_POINTS = 4096;

    // Fixed field widths.
    localparam int COORD_W    = 16;
    localparam int COEF_W     = 16;
    localparam int INDEX_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int POINT_W    = 3 * COORD_W;

    // Fraction bits of the Q2.14 coefficients.
    localparam int FRAC_BITS = 14;

    // Datapath widths of the shared multiplier and the accumulators.
    localparam int MUL_W  = 20;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 34;
    localparam int SQ_W   = 37;
    localparam int DIST_W = 39;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd3;

    // Reset values of the transform rows: the identity transform.
    localparam logic [CFG_DATA_W-1:0] ROW_X_RESET = 64'h4000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_Y_RESET = 64'h0000_4000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_Z_RESET = 64'h0000_0000_4000_0000;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

// File: hw/rtl/ntps_mul.sv
// Shared signed multiplier with a registered product.
module ntps_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [ntps_pkg::MUL_W-1:0]   a,
    input  logic signed [ntps_pkg::MUL_W-1:0]   b,
    output logic signed [ntps_pkg::PROD_W-1:0]  prod
);

    logic signed [ntps_pkg::PROD_W-1:0] prod_reg;

    // The product is captured only when the sequencer issues a multiply.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/nearest_transformed_point_search_unit.sv
// Top level of the nearest transformed point search unit.
//
// The unit holds up to MAX_POINTS local points in a single-port store. A load transaction
// writes one point; a load to an index at or above MAX_POINTS is dropped.
// A query transaction maps every stored point below vertex_count (clamped to MAX_POINTS)
// through the configured affine transform and returns the index of the first point at the
// least squared distance from the query point, or 0 when no point takes part. All arithmetic
// runs through one shared 20 x 20 bit multiplier, so each point is worked in turn: one store
// read, seven steps per transform row and one compare; a query holds the input channel
// stalled until its result is registered, longer while an earlier result still waits.
// The result waits in an output register, so loads are taken while an earlier result is
// still pending. Store entries read before they
// have been written return undefined data. Configuration writes are always accepted and must
// only be made while the unit is idle.
module nearest_transformed_point_search_unit #(
    parameter int MAX_POINTS = ntps_pkg::DEF_MAX_POINTS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // Input channel
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     func,
    input  logic [ntps_pkg::INDEX_W-1:0]             point_index,
    input  logic signed [ntps_pkg::COORD_W-1:0]      point_x,
    input  logic signed [ntps_pkg::COORD_W-1:0]      point_y,
    input  logic signed [ntps_pkg::COORD_W-1:0]      point_z,
    // Output channel
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [ntps_pkg::INDEX_W-1:0]             closest_index,
    // Configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ntps_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ntps_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = (IDX_W + 1 > ntps_pkg::COUNT_W) ? IDX_W + 1 : ntps_pkg::COUNT_W;
    localparam int CW_PAD = ntps_pkg::ACC_W - ntps_pkg::COEF_W - ntps_pkg::FRAC_BITS;

    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_M0,
        S_M1,
        S_M2,
        S_ADD,
        S_RND,
        S_SQ,
        S_ACC,
        S_CMP,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [ntps_pkg::CFG_DATA_W-1:0] row_x_reg;
    logic [ntps_pkg::CFG_DATA_W-1:0] row_y_reg;
    logic [ntps_pkg::CFG_DATA_W-1:0] row_z_reg;
    logic [ntps_pkg::COUNT_W-1:0]    vertex_count_reg;

    // Sequencer and datapath registers
    logic [IDX_W-1:0]                      idx_reg;
    logic [CW-1:0]                         count_reg;
    logic [1:0]                            row_reg;
    logic signed [ntps_pkg::COORD_W-1:0]   qx_reg;
    logic signed [ntps_pkg::COORD_W-1:0]   qy_reg;
    logic signed [ntps_pkg::COORD_W-1:0]   qz_reg;
    logic signed [ntps_pkg::ACC_W-1:0]     acc_reg;
    logic signed [ntps_pkg::MUL_W-1:0]     diff_reg;
    logic [ntps_pkg::DIST_W-1:0]           dist_reg;
    logic [ntps_pkg::DIST_W-1:0]           best_dist_reg;
    logic [IDX_W-1:0]                      best_idx_reg;
    logic                                  out_valid_reg;
    logic [ntps_pkg::INDEX_W-1:0]          closest_index_reg;

    // Point store
    logic [ntps_pkg::POINT_W-1:0]          mem [MAX_POINTS];
    logic [ntps_pkg::POINT_W-1:0]          rd_data_reg;

    // Combinational signals
    logic                                  in_accept;
    logic                                  out_accept;
    logic                                  out_free;
    logic                                  load_in_range;
    logic                                  mem_wr;
    logic [IDX_W-1:0]                      wr_addr;
    logic [CW-1:0]                         vc_ext;
    logic [CW-1:0]                         eff_count;
    logic [ntps_pkg::CFG_DATA_W-1:0]       row_word;
    logic signed [ntps_pkg::COORD_W-1:0]   q_sel;
    logic signed [ntps_pkg::COEF_W-1:0]    t_sel;
    logic signed [ntps_pkg::ACC_W-1:0]     t_scaled;
    logic signed [ntps_pkg::ACC_W-1:0]     round_bias;
    logic signed [ntps_pkg::ACC_W-1:0]     prod_acc;
    logic signed [ntps_pkg::MUL_W-1:0]     world_coord;
    logic [ntps_pkg::DIST_W-1:0]           sq_ext;
    logic [ntps_pkg::DIST_W-1:0]           dist_base;
    logic                                  last_point;
    logic                                  mul_en;
    logic signed [ntps_pkg::MUL_W-1:0]     mul_a;
    logic signed [ntps_pkg::MUL_W-1:0]     mul_b;
    logic signed [ntps_pkg::PROD_W-1:0]    mul_prod;

    // Handshakes
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign closest_index = closest_index_reg;
    assign cfg_ready  = 1'b1;

    // Load decode and query count clamp
    assign load_in_range = (32'(point_index) < 32'(MAX_POINTS));
    assign mem_wr        = in_accept && (func == ntps_pkg::FUNC_LOAD) && load_in_range;
    assign wr_addr       = IDX_W'(point_index);
    assign vc_ext        = CW'(vertex_count_reg);
    assign eff_count     = (vc_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : vc_ext;
    assign last_point    = (CW'(idx_reg) == count_reg - CW'(1));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg        <= ntps_pkg::ROW_X_RESET;
            row_y_reg        <= ntps_pkg::ROW_Y_RESET;
            row_z_reg        <= ntps_pkg::ROW_Z_RESET;
            vertex_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ntps_pkg::REG_ROW_X:        row_x_reg <= cfg_data;
                ntps_pkg::REG_ROW_Y:        row_y_reg <= cfg_data;
                ntps_pkg::REG_ROW_Z:        row_z_reg <= cfg_data;
                ntps_pkg::REG_VERTEX_COUNT:
                    vertex_count_reg <= cfg_data[ntps_pkg::COUNT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Point store: written by loads, read once per visited point.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_addr] <= {point_z, point_y, point_x};
        end
        if (state_reg == S_FETCH)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Select the transform row and query coordinate of the current axis.
    always_comb
    begin
        unique case (row_reg)
            ROW_X:
            begin
                row_word = row_x_reg;
                q_sel    = qx_reg;
            end
            ROW_Y:
            begin
                row_word = row_y_reg;
                q_sel    = qy_reg;
            end
            default:
            begin
                row_word = row_z_reg;
                q_sel    = qz_reg;
            end
        endcase
    end

    // Translation scaled to the product's fixed point, plus the rounding half.
    assign t_sel      = $signed(row_word[ntps_pkg::COEF_W-1:0]);
    assign t_scaled   = $signed({{CW_PAD{t_sel[ntps_pkg::COEF_W-1]}}, t_sel,
                                 {ntps_pkg::FRAC_BITS{1'b0}}});
    assign round_bias = $signed(ntps_pkg::ACC_W'(1) << (ntps_pkg::FRAC_BITS - 1));
    assign prod_acc   = $signed(mul_prod[ntps_pkg::ACC_W-1:0]);
    assign world_coord = acc_reg[ntps_pkg::ACC_W-1:ntps_pkg::FRAC_BITS];
    assign sq_ext     = ntps_pkg::DIST_W'(mul_prod[ntps_pkg::SQ_W-1:0]);
    assign dist_base  = (row_reg == ROW_X) ? '0 : dist_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_M0:
            begin
                mul_en = 1'b1;
                mul_a  = ntps_pkg::MUL_W'($signed(row_word[63:48]));
                mul_b  = ntps_pkg::MUL_W'($signed(rd_data_reg[15:0]));
            end
            S_M1:
            begin
                mul_en = 1'b1;
                mul_a  = ntps_pkg::MUL_W'($signed(row_word[47:32]));
                mul_b  = ntps_pkg::MUL_W'($signed(rd_data_reg[31:16]));
            end
            S_M2:
            begin
                mul_en = 1'b1;
                mul_a  = ntps_pkg::MUL_W'($signed(row_word[31:16]));
                mul_b  = ntps_pkg::MUL_W'($signed(rd_data_reg[47:32]));
            end
            S_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = diff_reg;
                mul_b  = diff_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    ntps_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // Sequencer: state, datapath registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            idx_reg           <= '0;
            count_reg         <= '0;
            row_reg           <= ROW_X;
            qx_reg            <= '0;
            qy_reg            <= '0;
            qz_reg            <= '0;
            acc_reg           <= '0;
            diff_reg          <= '0;
            dist_reg          <= '0;
            best_dist_reg     <= '0;
            best_idx_reg      <= '0;
            closest_index_reg <= '0;
        end
        else
        begin
            // A result taken while a new one is presented is replaced in the result state.
            if (out_accept && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (func == ntps_pkg::FUNC_QUERY))
                    begin
                        qx_reg       <= point_x;
                        qy_reg       <= point_y;
                        qz_reg       <= point_z;
                        count_reg    <= eff_count;
                        idx_reg      <= '0;
                        row_reg      <= ROW_X;
                        best_idx_reg <= '0;
                        state_reg    <= (eff_count == '0) ? S_OUT : S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    row_reg   <= ROW_X;
                    state_reg <= S_M0;
                end
                S_M0:
                begin
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    acc_reg   <= prod_acc;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg   <= acc_reg + prod_acc;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    acc_reg   <= acc_reg + prod_acc + t_scaled + round_bias;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    diff_reg  <= world_coord - ntps_pkg::MUL_W'(q_sel);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    dist_reg <= dist_base + sq_ext;
                    if (row_reg == ROW_Z)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= S_M0;
                    end
                end
                S_CMP:
                begin
                    // The first point always takes the lead; later ones only when strictly closer.
                    if ((idx_reg == '0) || (dist_reg < best_dist_reg))
                    begin
                        best_dist_reg <= dist_reg;
                        best_idx_reg  <= idx_reg;
                    end
                    if (last_point)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_FETCH;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        closest_index_reg <= ntps_pkg::INDEX_W'(best_idx_reg);
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The scan never visits a point at or beyond the clamped count.
    a_idx_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (CW'(idx_reg) < count_reg))
        else $error("point index ran past the vertex count");

    // The leading index is never ahead of the point being compared.
    a_best_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (best_idx_reg <= idx_reg))
        else $error("best index ahead of scan position");

    // A distance is compared only after all three axes have been summed.
    a_three_axes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $past(state_reg == S_ACC && row_reg == ROW_Z))
        else $error("distance compared before all axes were accumulated");

    // Leaving the result state always presents a result transaction.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("query finished without presenting a result");

endmodule
